// File: rtl/torus_signed_distance_defines.svh
// Assertion macros used by the RTL of the torus distance block.
`ifndef TORUS_SIGNED_DISTANCE_DEFINES_SVH
`define TORUS_SIGNED_DISTANCE_DEFINES_SVH

// The consequent must hold in the same cycle as the antecedent.
`define TSD_ASSERT_IMPL(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("torus_signed_distance: assertion failed");

// The consequent must hold in the cycle after the antecedent.
`define TSD_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("torus_signed_distance: assertion failed");

`endif

// File: rtl/tsd_pkg.sv
package tsd_pkg;

    localparam int COORD_W     = 32;
    localparam int ORIENT_W    = 64;
    localparam int RADIUS_W    = 31;
    localparam int QUAT_W      = 16;
    localparam int MAT_W       = 35;
    localparam int MAT_FRAC    = 28;
    localparam int CFG_DATA_W  = 64;
    localparam int CFG_INDEX_W = 3;

    localparam int P_W      = COORD_W + 1;
    localparam int PROD_W   = MAT_W + P_W;
    localparam int ACC_W    = PROD_W + 2;
    localparam int LOCAL_W  = ACC_W - MAT_FRAC;
    localparam int RING_W   = LOCAL_W + 1;
    localparam int DR_W     = ((RING_W > RADIUS_W) ? RING_W : RADIUS_W) + 1;
    localparam int TUBE_W   = DR_W + 1;
    localparam int DIST_W   = TUBE_W + 1;

    localparam logic [ORIENT_W-1:0] ORIENT_RESET = 64'h4000_0000_0000_0000;
    localparam logic [RADIUS_W-1:0] MAJOR_RESET  = 31'd65536;
    localparam logic [RADIUS_W-1:0] MINOR_RESET  = 31'd16384;

    typedef enum logic [CFG_INDEX_W-1:0] {
        REG_CENTER_X     = 3'd0,
        REG_CENTER_Y     = 3'd1,
        REG_CENTER_Z     = 3'd2,
        REG_ORIENTATION  = 3'd3,
        REG_MAJOR_RADIUS = 3'd4,
        REG_MINOR_RADIUS = 3'd5
    } cfg_reg_t;

    typedef struct packed {
        logic signed [COORD_W-1:0] point_x;
        logic signed [COORD_W-1:0] point_y;
        logic signed [COORD_W-1:0] point_z;
    } point_t;

    typedef struct packed {
        logic signed [COORD_W-1:0] distance;
        logic                      saturated;
    } result_t;

    typedef struct packed {
        logic signed [COORD_W-1:0] center_x;
        logic signed [COORD_W-1:0] center_y;
        logic signed [COORD_W-1:0] center_z;
        logic [ORIENT_W-1:0]       orient;
    } tsd_cfg_t;

endpackage

// File: rtl/tsd_rotate.sv
module tsd_rotate
    import tsd_pkg::*;
(
    input  logic                      clk,
    input  logic                      rst_n,
    input  logic                      en,
    input  tsd_cfg_t                  cfg,
    input  logic                      in_valid,
    input  point_t                    point,
    output logic                      out_valid,
    output logic signed [LOCAL_W-1:0] lx,
    output logic signed [LOCAL_W-1:0] ly,
    output logic signed [LOCAL_W-1:0] lz
);

    localparam logic signed [ACC_W-1:0] ROUND_BIAS = ACC_W'(1) << (MAT_FRAC - 1);

    logic signed [QUAT_W-1:0]   qw, qx, qy, qz;
    logic signed [2*QUAT_W-1:0] ww, xx, yy, zz, xy, wz, xz, wy, yz, wx;
    logic signed [MAT_W-1:0]    m_next [9];
    logic signed [MAT_W-1:0]    m_reg  [9];
    logic signed [P_W-1:0]      p_next [3];
    logic signed [P_W-1:0]      p_reg  [3];
    logic signed [PROD_W-1:0]   prod_next [9];
    logic signed [PROD_W-1:0]   prod_reg  [9];
    logic signed [ACC_W-1:0]    acc [3];
    logic signed [LOCAL_W-1:0]  l_reg [3];
    logic [2:0]                 valid_reg;

    assign qw = cfg.orient[4*QUAT_W-1 -: QUAT_W];
    assign qx = cfg.orient[3*QUAT_W-1 -: QUAT_W];
    assign qy = cfg.orient[2*QUAT_W-1 -: QUAT_W];
    assign qz = cfg.orient[QUAT_W-1 -: QUAT_W];

    assign ww = qw * qw;
    assign xx = qx * qx;
    assign yy = qy * qy;
    assign zz = qz * qz;
    assign xy = qx * qy;
    assign wz = qw * qz;
    assign xz = qx * qz;
    assign wy = qw * qy;
    assign yz = qy * qz;
    assign wx = qw * qx;

    // Rotation matrix in row-major order, Q7.28.
    always_comb
    begin
        m_next[0] = MAT_W'(ww) + MAT_W'(xx) - MAT_W'(yy) - MAT_W'(zz);
        m_next[1] = (MAT_W'(xy) - MAT_W'(wz)) <<< 1;
        m_next[2] = (MAT_W'(xz) + MAT_W'(wy)) <<< 1;
        m_next[3] = (MAT_W'(xy) + MAT_W'(wz)) <<< 1;
        m_next[4] = MAT_W'(ww) - MAT_W'(xx) + MAT_W'(yy) - MAT_W'(zz);
        m_next[5] = (MAT_W'(yz) - MAT_W'(wx)) <<< 1;
        m_next[6] = (MAT_W'(xz) - MAT_W'(wy)) <<< 1;
        m_next[7] = (MAT_W'(yz) + MAT_W'(wx)) <<< 1;
        m_next[8] = MAT_W'(ww) - MAT_W'(xx) - MAT_W'(yy) + MAT_W'(zz);
    end

    always_ff @(posedge clk)
    begin
        m_reg <= m_next;
    end

    assign p_next[0] = P_W'(point.point_x) - P_W'(cfg.center_x);
    assign p_next[1] = P_W'(point.point_y) - P_W'(cfg.center_y);
    assign p_next[2] = P_W'(point.point_z) - P_W'(cfg.center_z);

    // Product k multiplies matrix entry k by the point component of its row.
    for (genvar k = 0; k < 9; k++)
    begin : g_prod
        assign prod_next[k] = PROD_W'(m_reg[k]) * PROD_W'(p_reg[k/3]);
    end

    // Local coordinate c is column c of the matrix dotted with the point.
    for (genvar c = 0; c < 3; c++)
    begin : g_acc
        assign acc[c] = ACC_W'(prod_reg[c]) + ACC_W'(prod_reg[c+3])
                      + ACC_W'(prod_reg[c+6]) + ROUND_BIAS;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= '0;
        end
        else if (en)
        begin
            valid_reg <= {valid_reg[1:0], in_valid};
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            p_reg    <= p_next;
            prod_reg <= prod_next;
            for (int c = 0; c < 3; c++)
            begin
                l_reg[c] <= acc[c][ACC_W-1:MAT_FRAC];
            end
        end
    end

    assign out_valid = valid_reg[2];
    assign lx        = l_reg[0];
    assign ly        = l_reg[1];
    assign lz        = l_reg[2];

endmodule

// File: rtl/tsd_square_sum.sv
module tsd_square_sum
    import tsd_pkg::*;
#(
    parameter int A_W = 42
)
(
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  en,
    input  logic                  in_valid,
    input  logic signed [A_W-1:0] a,
    input  logic signed [A_W-1:0] b,
    output logic                  out_valid,
    output logic [2*A_W+1:0]      sum
);

    localparam int H    = (A_W + 1) / 2;
    localparam int HI_W = A_W - H;
    localparam int SQ_W = 2 * A_W;
    localparam int SUM_W = 2 * A_W + 2;

    logic [1:0][A_W-1:0]    mag;
    logic [1:0][2*HI_W-1:0] hh_reg;
    logic [1:0][A_W-1:0]    hl_reg;
    logic [1:0][2*H-1:0]    ll_reg;
    logic [1:0][SQ_W-1:0]   sq_reg;
    logic [SUM_W-1:0]       sum_reg;
    logic [2:0]             valid_reg;

    assign mag[0] = a[A_W-1] ? $unsigned(-a) : $unsigned(a);
    assign mag[1] = b[A_W-1] ? $unsigned(-b) : $unsigned(b);

    // Each square is split into high and low halves to keep the multipliers narrow.
    always_ff @(posedge clk)
    begin
        if (en)
        begin
            for (int j = 0; j < 2; j++)
            begin
                hh_reg[j] <= (2*HI_W)'(mag[j][A_W-1:H]) * (2*HI_W)'(mag[j][A_W-1:H]);
                hl_reg[j] <= A_W'(mag[j][A_W-1:H]) * A_W'(mag[j][H-1:0]);
                ll_reg[j] <= (2*H)'(mag[j][H-1:0]) * (2*H)'(mag[j][H-1:0]);
                sq_reg[j] <= (SQ_W'(hh_reg[j]) << (2*H)) + (SQ_W'(hl_reg[j]) << (H+1))
                           + SQ_W'(ll_reg[j]);
            end
            sum_reg <= SUM_W'(sq_reg[0]) + SUM_W'(sq_reg[1]);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= '0;
        end
        else if (en)
        begin
            valid_reg <= {valid_reg[1:0], in_valid};
        end
    end

    assign out_valid = valid_reg[2];
    assign sum       = sum_reg;

endmodule

// File: rtl/tsd_sqrt.sv
module tsd_sqrt
    import tsd_pkg::*;
#(
    parameter int IN_W = 86
)
(
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  en,
    input  logic                  in_valid,
    input  logic [IN_W-1:0]       radicand,
    output logic                  out_valid,
    output logic [IN_W/2-1:0]     root
);

    localparam int N = IN_W / 2;

    logic [N+1:0]  rem_reg  [N];
    logic [N-1:0]  root_reg [N];
    logic [IN_W-1:0] rad_reg [N];
    logic [N-1:0]  vld_reg;
    logic [N+1:0]  src_rem  [N];
    logic [N-1:0]  src_root [N];
    logic [IN_W-1:0] src_rad [N];
    logic [N-1:0]  src_vld;
    logic [N-1:0]  out_reg;
    logic          out_valid_reg;

    // One result bit per stage, restoring method.
    for (genvar k = 0; k < N; k++)
    begin : g_stage
        logic [N+1:0] remsh;
        logic [N+1:0] trial;
        logic [N+1:0] rem_next;
        logic [N-1:0] root_next;

        if (k == 0)
        begin : g_first
            assign src_rem[k]  = '0;
            assign src_root[k] = '0;
            assign src_rad[k]  = radicand;
            assign src_vld[k]  = in_valid;
        end
        else
        begin : g_rest
            assign src_rem[k]  = rem_reg[k-1];
            assign src_root[k] = root_reg[k-1];
            assign src_rad[k]  = rad_reg[k-1];
            assign src_vld[k]  = vld_reg[k-1];
        end

        always_comb
        begin
            remsh = {src_rem[k][N-1:0], src_rad[k][IN_W-1 -: 2]};
            trial = {src_root[k], 2'b01};
            if (remsh >= trial)
            begin
                rem_next  = remsh - trial;
                root_next = {src_root[k][N-2:0], 1'b1};
            end
            else
            begin
                rem_next  = remsh;
                root_next = {src_root[k][N-2:0], 1'b0};
            end
        end

        always_ff @(posedge clk)
        begin
            if (en)
            begin
                rem_reg[k]  <= rem_next;
                root_reg[k] <= root_next;
                rad_reg[k]  <= src_rad[k] << 2;
            end
        end

        always_ff @(posedge clk or negedge rst_n)
        begin
            if (!rst_n)
            begin
                vld_reg[k] <= 1'b0;
            end
            else if (en)
            begin
                vld_reg[k] <= src_vld[k];
            end
        end
    end

    // Round to nearest: step up when the remainder exceeds the floor root.
    always_ff @(posedge clk)
    begin
        if (en)
        begin
            out_reg <= root_reg[N-1] + N'(rem_reg[N-1] > {2'b00, root_reg[N-1]});
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (en)
        begin
            out_valid_reg <= vld_reg[N-1];
        end
    end

    assign out_valid = out_valid_reg;
    assign root      = out_reg;

endmodule

// File: rtl/torus_signed_distance.sv
// Signed distance from a query point to a configured torus, Q16.16.
// Input channel point_valid/point_ready/point carries one query point per
// transfer; output channel result_valid/result_ready/result carries its
// signed distance and a saturation flag, in the same order.
// Configuration is written through cfg_wr_en/cfg_index/cfg_data, one register per
// cycle; the user must write it only while no point is in flight (the block does not enforce this).
// The datapath is a 100-stage pipeline that feeds the output register.
// Most of that depth is the two square roots, one result bit per stage
// (43 and 45 stages).
// A new point can be taken every cycle while point_ready is high, so throughput is one point per cycle.
// The output register is backed by one skid entry; the pipeline only halts
// when both are full, and then point_ready is low until result_ready.
// Reset empties the pipeline and loads the identity orientation, a zero
// center, major radius 1.0 and minor radius 0.25.
`include "torus_signed_distance_defines.svh"

module torus_signed_distance
    import tsd_pkg::*;
(
    input  logic                   clk,
    input  logic                   rst_n,
    input  logic                   point_valid,
    output logic                   point_ready,
    input  point_t                 point,
    output logic                   result_valid,
    input  logic                   result_ready,
    output result_t                result,
    input  logic                   cfg_wr_en,
    input  logic [CFG_INDEX_W-1:0] cfg_index,
    input  logic [CFG_DATA_W-1:0]  cfg_data
);

    localparam int LY_DELAY = RING_W + 5;
    localparam logic [COORD_W-1:0] COORD_MAX = {1'b0, {(COORD_W-1){1'b1}}};
    localparam logic [COORD_W-1:0] COORD_MIN = {1'b1, {(COORD_W-1){1'b0}}};
    localparam logic signed [DIST_W-1:0] DIST_MAX =
        {{(DIST_W-COORD_W+1){1'b0}}, {(COORD_W-1){1'b1}}};
    localparam logic signed [DIST_W-1:0] DIST_MIN =
        {{(DIST_W-COORD_W+1){1'b1}}, {(COORD_W-1){1'b0}}};

    tsd_cfg_t              cfg_reg, cfg_next;
    logic [RADIUS_W-1:0]   major_reg, major_next;
    logic [RADIUS_W-1:0]   minor_reg, minor_next;

    logic                  adv;
    logic                  rot_valid;
    logic signed [LOCAL_W-1:0] lx, ly, lz;
    logic signed [LOCAL_W-1:0] ly_pipe_reg [LY_DELAY];
    logic                  sq1_valid;
    logic [2*LOCAL_W+1:0]  sq1_sum;
    logic                  ring_valid;
    logic [RING_W-1:0]     ring;
    logic signed [DR_W-1:0] dr_reg;
    logic                  dr_valid_reg;
    logic                  sq2_valid;
    logic [2*DR_W+1:0]     sq2_sum;
    logic                  tail_valid;
    logic [TUBE_W-1:0]     tube;
    logic signed [DIST_W-1:0] dist_full;
    result_t               tail_data;

    logic                  out_valid_reg, out_valid_next;
    logic                  skid_valid_reg, skid_valid_next;
    logic                  out_load_tail, out_load_skid, skid_load;
    result_t               out_reg, skid_reg;

    always_comb
    begin
        cfg_next   = cfg_reg;
        major_next = major_reg;
        minor_next = minor_reg;
        if (cfg_wr_en)
        begin
            case (cfg_reg_t'(cfg_index))
                REG_CENTER_X:     cfg_next.center_x = cfg_data[COORD_W-1:0];
                REG_CENTER_Y:     cfg_next.center_y = cfg_data[COORD_W-1:0];
                REG_CENTER_Z:     cfg_next.center_z = cfg_data[COORD_W-1:0];
                REG_ORIENTATION:  cfg_next.orient   = cfg_data[ORIENT_W-1:0];
                REG_MAJOR_RADIUS: major_next        = cfg_data[RADIUS_W-1:0];
                REG_MINOR_RADIUS: minor_next        = cfg_data[RADIUS_W-1:0];
                default:          cfg_next          = cfg_reg;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg   <= '{center_x: '0, center_y: '0, center_z: '0, orient: ORIENT_RESET};
            major_reg <= MAJOR_RESET;
            minor_reg <= MINOR_RESET;
        end
        else
        begin
            cfg_reg   <= cfg_next;
            major_reg <= major_next;
            minor_reg <= minor_next;
        end
    end

    assign adv         = !skid_valid_reg;
    assign point_ready = adv;

    tsd_rotate u_rotate (
        .clk       (clk),
        .rst_n     (rst_n),
        .en        (adv),
        .cfg       (cfg_reg),
        .in_valid  (point_valid && point_ready),
        .point     (point),
        .out_valid (rot_valid),
        .lx        (lx),
        .ly        (ly),
        .lz        (lz)
    );

    tsd_square_sum #(.A_W(LOCAL_W)) u_ring_sq (
        .clk       (clk),
        .rst_n     (rst_n),
        .en        (adv),
        .in_valid  (rot_valid),
        .a         (lx),
        .b         (lz),
        .out_valid (sq1_valid),
        .sum       (sq1_sum)
    );

    tsd_sqrt #(.IN_W(2*LOCAL_W+2)) u_ring_sqrt (
        .clk       (clk),
        .rst_n     (rst_n),
        .en        (adv),
        .in_valid  (sq1_valid),
        .radicand  (sq1_sum),
        .out_valid (ring_valid),
        .root      (ring)
    );

    // The local Y coordinate waits here until the radial offset is ready.
    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            ly_pipe_reg[0] <= ly;
            for (int i = 1; i < LY_DELAY; i++)
            begin
                ly_pipe_reg[i] <= ly_pipe_reg[i-1];
            end
            dr_reg <= $signed({{(DR_W-RING_W){1'b0}}, ring})
                    - $signed({{(DR_W-RADIUS_W){1'b0}}, major_reg});
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            dr_valid_reg <= 1'b0;
        end
        else if (adv)
        begin
            dr_valid_reg <= ring_valid;
        end
    end

    tsd_square_sum #(.A_W(DR_W)) u_tube_sq (
        .clk       (clk),
        .rst_n     (rst_n),
        .en        (adv),
        .in_valid  (dr_valid_reg),
        .a         (dr_reg),
        .b         (DR_W'(ly_pipe_reg[LY_DELAY-1])),
        .out_valid (sq2_valid),
        .sum       (sq2_sum)
    );

    tsd_sqrt #(.IN_W(2*DR_W+2)) u_tube_sqrt (
        .clk       (clk),
        .rst_n     (rst_n),
        .en        (adv),
        .in_valid  (sq2_valid),
        .radicand  (sq2_sum),
        .out_valid (tail_valid),
        .root      (tube)
    );

    always_comb
    begin
        dist_full = $signed({1'b0, tube}) - $signed({{(DIST_W-RADIUS_W){1'b0}}, minor_reg});
        if (dist_full > DIST_MAX)
        begin
            tail_data.distance  = COORD_MAX;
            tail_data.saturated = 1'b1;
        end
        else if (dist_full < DIST_MIN)
        begin
            tail_data.distance  = COORD_MIN;
            tail_data.saturated = 1'b1;
        end
        else
        begin
            tail_data.distance  = dist_full[COORD_W-1:0];
            tail_data.saturated = 1'b0;
        end
    end

    // Output register with one skid entry behind it.
    always_comb
    begin
        out_load_tail   = 1'b0;
        out_load_skid   = 1'b0;
        skid_load       = 1'b0;
        out_valid_next  = out_valid_reg;
        skid_valid_next = skid_valid_reg;
        if (skid_valid_reg)
        begin
            if (result_ready)
            begin
                out_load_skid   = 1'b1;
                skid_valid_next = 1'b0;
            end
        end
        else if (tail_valid)
        begin
            if (!out_valid_reg || result_ready)
            begin
                out_load_tail  = 1'b1;
                out_valid_next = 1'b1;
            end
            else
            begin
                skid_load       = 1'b1;
                skid_valid_next = 1'b1;
            end
        end
        else if (result_ready)
        begin
            out_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg  <= 1'b0;
            skid_valid_reg <= 1'b0;
        end
        else
        begin
            out_valid_reg  <= out_valid_next;
            skid_valid_reg <= skid_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (out_load_tail)
        begin
            out_reg <= tail_data;
        end
        else if (out_load_skid)
        begin
            out_reg <= skid_reg;
        end
        if (skid_load)
        begin
            skid_reg <= tail_data;
        end
    end

    assign result_valid = out_valid_reg;
    assign result       = out_reg;

    `TSD_ASSERT_IMPL(a_skid_needs_out, clk, rst_n, skid_valid_reg, out_valid_reg)
    `TSD_ASSERT_NEXT(a_stall_fills_skid, clk, rst_n, (tail_valid && !skid_valid_reg && out_valid_reg && !result_ready), skid_valid_reg)
    `TSD_ASSERT_IMPL(a_sat_is_clamped, clk, rst_n, (result_valid && result.saturated), (result.distance == COORD_MAX || result.distance == COORD_MIN))

endmodule
